/* sv/rfidd_pkg.sv */
`default_nettype none

package rfidd_pkg;

    // tag table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TAG_COUNT_W = 6;

    // request function codes
    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // frame format
    localparam logic [7:0]  END_BYTE    = 8'h7E;
    localparam logic [7:0]  FRAME_LEN_A = 8'd19;
    localparam logic [7:0]  FRAME_LEN_B = 8'd23;
    localparam logic [7:0]  IDX_MAX     = 8'd255;
    localparam logic [31:0] SENTINEL_ID = 32'hBB01FF00;
    localparam logic [16:0] IDLE_MAX    = 17'h1FFFF;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_NEW    = 3'd1;
    localparam logic [2:0] EV_DUP    = 3'd2;
    localparam logic [2:0] EV_REJECT = 3'd3;
    localparam logic [2:0] EV_DROP   = 3'd4;
    localparam logic [2:0] EV_FULL   = 3'd5;
    localparam logic [2:0] EV_DONE   = 3'd6;

    // configuration register indexes
    localparam logic REG_IDLE_TIMEOUT = 1'b0;
    localparam logic REG_REJECT_ZERO  = 1'b1;

    // outcome of one request in the frame front end
    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] id;
        logic        lookup;
        logic        scan;
    } frame_res_t;

    // table search status
    typedef struct packed {
        logic       done;
        logic [2:0] ev;
    } tbl_stat_t;

endpackage

`default_nettype wire

/* sv/rfid_inventory_frame_dedup_unit.sv */
// RFID inventory frame parser with tag de-duplication.
// Input channel (in_valid / in_stall) carries one request per item: func
// selects a reader byte, a millisecond tick or the start of a new scan,
// rx_byte holds the reader byte. Output channel (out_valid / out_stall)
// returns exactly one result per request: event_res, tag_id, tag_count and
// scanning, in request order.
// Ticks, starts and ordinary bytes pass from the pending result registers
// into the output register. An end byte that closes a kept frame and is not
// dropped first searches the tag table, held in a RAM with one write port and
// a registered read port, one entry per cycle, stopping at a hit or at the count.
// A new request is accepted only once the previous result has moved into the
// output register; frame ends that need a table search hold it off longer.
// The output register lets the next request be accepted while a result
// still waits; when out_stall holds a result and the following one is
// ready, the block raises in_stall until the output register frees up.
// Reset clears all control state, sets idle_timeout_ms to 100 and
// reject_zero_id to 0, and leaves the block idle with no scan running.
// The tag table RAM needs no clearing: only entries below the count are read.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered and apply to later requests.
`default_nettype none

module rfid_inventory_frame_dedup_unit import rfidd_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_res,
    output logic [31:0]      tag_id,
    output logic [5:0]       tag_count,
    output logic             scanning
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [15:0]      timeout_reg;
    logic             reject_zero_reg;
    logic             accept;
    logic             out_free;
    frame_res_t       fres;
    tbl_stat_t        tstat;
    logic [CNT_W-1:0] count;
    logic             tbl_lookup;
    logic             tbl_clear;
    logic [2:0]       pend_ev_reg;
    logic [31:0]      pend_id_reg;
    logic             pend_scan_reg;
    logic             out_valid_reg;
    logic [2:0]       event_reg;
    logic [31:0]      tag_id_reg;
    logic [5:0]       tag_count_reg;
    logic             scanning_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= 16'd100;
            reject_zero_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IDLE_TIMEOUT: timeout_reg     <= cfg_data;
                REG_REJECT_ZERO:  reject_zero_reg <= cfg_data[0];
                default:          timeout_reg     <= timeout_reg;
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign tbl_lookup = accept && fres.lookup;
    assign tbl_clear  = accept && (func == FUNC_START);

    rfidd_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (func),
        .rx_byte      (rx_byte),
        .idle_timeout (timeout_reg),
        .reject_zero  (reject_zero_reg),
        .res          (fres)
    );

    rfidd_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (tbl_clear),
        .lookup (tbl_lookup),
        .key    (fres.id),
        .stat   (tstat),
        .count  (count)
    );

    // request sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = fres.lookup ? ST_LOOK : ST_EMIT;
                end
            end
            ST_LOOK:
            begin
                if (tstat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // pending result of the request in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_ev_reg   <= fres.ev;
            pend_id_reg   <= fres.id;
            pend_scan_reg <= fres.scan;
        end
        else if (state_reg == ST_LOOK && tstat.done)
        begin
            pend_ev_reg <= tstat.ev;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            event_reg     <= pend_ev_reg;
            tag_id_reg    <= pend_id_reg;
            tag_count_reg <= TAG_COUNT_W'(count);
            scanning_reg  <= pend_scan_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign tag_id    = tag_id_reg;
    assign tag_count = tag_count_reg;
    assign scanning  = scanning_reg;

    // the reported count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tag_count <= TAG_COUNT_W'(TABLE_DEPTH)))
        else $error("tag count beyond table depth");

    // a finished scan is reported as no longer scanning
    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_DONE) |-> !scanning)
        else $error("scan done while still scanning");

    // a rejected frame carries no tag id
    a_reject_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_REJECT) |-> (tag_id == '0))
        else $error("rejected frame with nonzero id");

    // a table search is only started from the idle state
    a_lookup_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> $past(state_reg == ST_IDLE || state_reg == ST_LOOK))
        else $error("table search entered out of order");

endmodule

`default_nettype wire

/* sv/rfidd_ram.sv */
`default_nettype none

module rfidd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/rfidd_frame.sv */
`default_nettype none

module rfidd_frame import rfidd_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] idle_timeout,
    input  wire logic        reject_zero,
    output frame_res_t       res
);

    logic [7:0]      idx_reg, idx_next;
    logic [7:0][7:0] recent_reg, recent_next;
    logic [16:0]     idle_reg, idle_next;
    logic            scan_reg, scan_next;
    logic [31:0]     frame_id;
    logic [16:0]     idle_inc;
    logic            kept;
    logic [2:0]      ev;
    logic [31:0]     id;
    logic            lookup;

    // id bytes sit seven to four places before the end byte
    assign frame_id = {recent_reg[6], recent_reg[5], recent_reg[4], recent_reg[3]};
    assign idle_inc = (idle_reg < IDLE_MAX) ? idle_reg + 17'd1 : idle_reg;
    assign kept     = (idx_reg == FRAME_LEN_A) || (idx_reg == FRAME_LEN_B);

    // per-request state update and classification
    always_comb
    begin
        idx_next    = idx_reg;
        recent_next = recent_reg;
        idle_next   = idle_reg;
        scan_next   = scan_reg;
        ev          = EV_NONE;
        id          = '0;
        lookup      = 1'b0;
        priority if (func == FUNC_START)
        begin
            idx_next    = '0;
            recent_next = '0;
            idle_next   = '0;
            scan_next   = 1'b1;
        end
        else if (func == FUNC_TICK && scan_reg)
        begin
            idle_next = idle_inc;
            if (idle_inc > {1'b0, idle_timeout})
            begin
                scan_next = 1'b0;
                ev        = EV_DONE;
            end
        end
        else if (func == FUNC_BYTE && scan_reg)
        begin
            if (rx_byte == END_BYTE)
            begin
                if (kept)
                begin
                    id = frame_id;
                    if (frame_id == SENTINEL_ID || (reject_zero && frame_id == '0))
                    begin
                        ev = EV_DROP;
                    end
                    else
                    begin
                        lookup = 1'b1;
                    end
                end
                else
                begin
                    ev = EV_REJECT;
                end
                idx_next = '0;
            end
            else
            begin
                if (idx_reg < IDX_MAX)
                begin
                    idx_next = idx_reg + 8'd1;
                end
                idle_next = '0;
            end
            recent_next = {recent_reg[6:0], rx_byte};
        end
        else
        begin
            // unused func value or no scan running: state holds
        end
    end

    assign res = '{ev: ev, id: id, lookup: lookup, scan: scan_next};

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            recent_reg <= '0;
            idle_reg   <= '0;
            scan_reg   <= 1'b0;
        end
        else if (accept)
        begin
            idx_reg    <= idx_next;
            recent_reg <= recent_next;
            idle_reg   <= idle_next;
            scan_reg   <= scan_next;
        end
    end

endmodule

`default_nettype wire

/* sv/rfidd_table.sv */
`default_nettype none

module rfidd_table import rfidd_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             lookup,
    input  wire logic [31:0]      key,
    output tbl_stat_t             stat,
    output logic      [CNT_W-1:0] count
);

    localparam logic T_IDLE = 1'b0;
    localparam logic T_SCAN = 1'b1;

    logic             tstate_reg, tstate_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      key_reg;
    logic [31:0]      ram_q;
    logic             issue;
    logic             hit;
    logic             finish;
    logic             full;
    logic             ram_we;

    // one read issued per cycle, compared when the data returns
    assign issue  = (tstate_reg == T_SCAN) && (rd_idx_reg < count_reg);
    assign hit    = (tstate_reg == T_SCAN) && pend_reg && (ram_q == key_reg);
    assign finish = (tstate_reg == T_SCAN) && !pend_reg && !issue;
    assign full   = count_reg >= CNT_W'(TABLE_DEPTH);
    assign ram_we = finish && !full;

    rfidd_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[TBL_AW-1:0]),
        .wdata (key_reg),
        .re    (issue),
        .raddr (rd_idx_reg[TBL_AW-1:0]),
        .rdata (ram_q)
    );

    // search sequencer
    always_comb
    begin
        tstate_next = tstate_reg;
        rd_idx_next = rd_idx_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        unique case (tstate_reg)
            T_IDLE:
            begin
                if (clear)
                begin
                    count_next = '0;
                end
                if (lookup)
                begin
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    tstate_next = T_SCAN;
                end
            end
            T_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                pend_next = issue;
                if (ram_we)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (hit || finish)
                begin
                    tstate_next = T_IDLE;
                end
            end
            default:
            begin
                tstate_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstate_reg <= T_IDLE;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            tstate_reg <= tstate_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
        end
    end

    // search key
    always_ff @(posedge clk)
    begin
        if (tstate_reg == T_IDLE && lookup)
        begin
            key_reg <= key;
        end
    end

    assign stat  = '{done: hit || finish, ev: hit ? EV_DUP : (full ? EV_FULL : EV_NEW)};
    assign count = count_reg;

    // a store never lands past the end of the table
    a_we_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < CNT_W'(TABLE_DEPTH)))
        else $error("table write beyond depth");

    // a new tag grows the table by exactly one
    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && stat.ev == EV_NEW) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("new tag did not bump count");

endmodule

`default_nettype wire
